// File: hdl/spq_pkg.sv
// shared types and constants for the stable priority queue
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  // default number of cells in the chain
  localparam int DEPTH_DEF = 16;

  // field widths
  localparam int ID_W  = 16;
  localparam int REQ_W = 37;
  localparam int PRI_W = 4;
  localparam int TYP_W = 2;
  localparam int DST_W = 16;
  localparam int OCC_W = 5;

  // item kind codes
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_POP    = 1'b1
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } op_t;

  // one stored record
  typedef struct packed {
    logic [ID_W-1:0]  record_id;
    logic [REQ_W-1:0] requester;
    logic [PRI_W-1:0] priority_val;
    logic [TYP_W-1:0] incident_type;
    logic [DST_W-1:0] district;
  } rec_t;

  // control shared by all cells
  typedef struct packed {
    op_t  op;
    rec_t rec;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/spq_cell.sv
// one cell of the sorted shift chain: holds a record and moves with its neighbors
`timescale 1ns / 1ps
`default_nettype none
module spq_cell (
  input  wire                      clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire                      occupied,
  input  wire                      prev_ge,
  input  wire spq_pkg::rec_t       left_rec,
  input  wire spq_pkg::rec_t       right_rec,
  output spq_pkg::rec_t            rec,
  output logic                     ge
);

  spq_pkg::rec_t rec_r;
  spq_pkg::rec_t rec_nxt;

  // this cell holds a record that stays ahead of the new one
  assign ge  = occupied && (rec_r.priority_val >= ctrl.rec.priority_val);
  assign rec = rec_r;

  // keep, take the new record, or shift from a neighbor
  always_comb begin
    rec_nxt = rec_r;
    case (ctrl.op)
      spq_pkg::OP_INSERT: begin
        if (ge) begin
          rec_nxt = rec_r;
        end else if (prev_ge) begin
          rec_nxt = ctrl.rec;
        end else begin
          rec_nxt = left_rec;
        end
      end
      spq_pkg::OP_POP: begin
        rec_nxt = right_rec;
      end
      default: begin
        rec_nxt = rec_r;
      end
    endcase
  end

  // record storage
  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule
`default_nettype wire

// File: hdl/stable_priority_queue_unit.sv
// top level of the stable priority queue: cell chain, count and result register
//
// usage
//   input channel: drive start high with in_kind and the record fields; the item
//   is taken at a rising edge where start is high and busy is low. in_kind 0
//   inserts the record behind all stored records of equal or higher priority,
//   in_kind 1 removes the head record.
//   result channel: in the cycle after an item is taken, out_valid is high for
//   exactly one cycle with out_status, the popped record fields (zero unless a
//   record was popped) and out_occupancy, the record count after the item.
//   throughput: one item per cycle while busy is low; every cell compares its
//   priority with the new record and loads, holds or shifts in the same cycle,
//   so no item waits on another.
//   reset: rst_n low empties the queue and holds busy high; stored records
//   are not cleared, only the count is. the receiver cannot stall: each result
//   is shown once and must be taken in that cycle.
//   a full queue drops an insert with status 3; a pop on empty gives status 2.
`timescale 1ns / 1ps
`default_nettype none
module stable_priority_queue_unit #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  wire                        in_kind,
  input  wire [spq_pkg::ID_W-1:0]    in_record_id,
  input  wire [spq_pkg::REQ_W-1:0]   in_requester_code,
  input  wire [spq_pkg::PRI_W-1:0]   in_priority_req,
  input  wire [spq_pkg::TYP_W-1:0]   in_incident_type,
  input  wire [spq_pkg::DST_W-1:0]   in_district_id,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [spq_pkg::ID_W-1:0]   out_record_id,
  output logic [spq_pkg::REQ_W-1:0]  out_requester_code,
  output logic [spq_pkg::PRI_W-1:0]  out_priority,
  output logic [spq_pkg::TYP_W-1:0]  out_incident_type,
  output logic [spq_pkg::DST_W-1:0]  out_district_id,
  output logic [spq_pkg::OCC_W-1:0]  out_occupancy
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic                accept;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::status_t    status_nxt;
  spq_pkg::rec_t       pop_rec;
  spq_pkg::rec_t       cell_rec [DEPTH];
  logic [DEPTH-1:0]    cell_ge;

  logic                out_valid_r;
  spq_pkg::status_t    status_r;
  spq_pkg::rec_t       out_rec_r;
  logic [CW-1:0]       occ_r;
  logic [CW+spq_pkg::OCC_W-1:0] occ_wide;

  assign busy   = ~rst_n;
  assign accept = start && !busy;

  // decode the item into a cell operation and its result
  always_comb begin
    ctrl.op                = spq_pkg::OP_HOLD;
    ctrl.rec.record_id     = in_record_id;
    ctrl.rec.requester     = in_requester_code;
    ctrl.rec.priority_val  = in_priority_req;
    ctrl.rec.incident_type = in_incident_type;
    ctrl.rec.district      = in_district_id;
    count_nxt              = count_r;
    status_nxt             = spq_pkg::ST_INSERTED;
    pop_rec                = '0;
    if (accept) begin
      if (in_kind == spq_pkg::KIND_INSERT) begin
        if (count_r == FULL_CNT) begin
          status_nxt = spq_pkg::ST_FULL;
        end else begin
          ctrl.op    = spq_pkg::OP_INSERT;
          count_nxt  = count_r + 1'b1;
          status_nxt = spq_pkg::ST_INSERTED;
        end
      end else begin
        if (count_r == '0) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          ctrl.op    = spq_pkg::OP_POP;
          count_nxt  = count_r - 1'b1;
          status_nxt = spq_pkg::ST_POPPED;
          pop_rec    = cell_rec[0];
        end
      end
    end
  end

  // chain of cells, head at index zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::rec_t left_rec;
    spq_pkg::rec_t right_rec;
    logic          prev_ge;

    if (i == 0) begin : g_head
      assign left_rec = ctrl.rec;
      assign prev_ge  = 1'b1;
    end else begin : g_body
      assign left_rec = cell_rec[i-1];
      assign prev_ge  = cell_ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_rec = cell_rec[i];
    end else begin : g_inner
      assign right_rec = cell_rec[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (CW'(i) < count_r),
      .prev_ge   (prev_ge),
      .left_rec  (left_rec),
      .right_rec (right_rec),
      .rec       (cell_rec[i]),
      .ge        (cell_ge[i])
    );
  end

  // record count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      out_rec_r <= pop_rec;
      occ_r     <= count_nxt;
    end
  end

  // occupancy keeps its low five bits
  assign occ_wide = {{spq_pkg::OCC_W{1'b0}}, occ_r};

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_record_id      = out_rec_r.record_id;
  assign out_requester_code = out_rec_r.requester;
  assign out_priority       = out_rec_r.priority_val;
  assign out_incident_type  = out_rec_r.incident_type;
  assign out_district_id    = out_rec_r.district;
  assign out_occupancy      = occ_wide[spq_pkg::OCC_W-1:0];

endmodule
`default_nettype wire

// File: hdl/spq_checker.sv
// port-level checks for the stable priority queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module spq_checker #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       start,
  input wire                       busy,
  input wire                       in_kind,
  input wire                       out_valid,
  input wire [1:0]                 out_status,
  input wire [spq_pkg::ID_W-1:0]   out_record_id,
  input wire [spq_pkg::REQ_W-1:0]  out_requester_code,
  input wire [spq_pkg::PRI_W-1:0]  out_priority,
  input wire [spq_pkg::TYP_W-1:0]  out_incident_type,
  input wire [spq_pkg::DST_W-1:0]  out_district_id,
  input wire [spq_pkg::OCC_W-1:0]  out_occupancy
);

  localparam int FULL_MOD = DEPTH % 32;
  localparam logic [spq_pkg::OCC_W-1:0] FULL_OCC = FULL_MOD[spq_pkg::OCC_W-1:0];

  logic acc;
  logic no_rec;

  assign acc    = start && !busy;
  assign no_rec = (out_record_id == '0) && (out_requester_code == '0) &&
                  (out_priority == '0) && (out_incident_type == '0) &&
                  (out_district_id == '0);

  // exactly one result per accepted item, in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc == 1'b1 || acc == 1'b0) |=> (out_valid == $past(acc)))
    else $error("result strobe does not follow item acceptance");

  // only a valid pop carries record fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != spq_pkg::ST_POPPED) |-> no_rec)
    else $error("record fields not zero on non-pop result");

  // empty and full reports match the occupancy shown
  a_bound_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_status != spq_pkg::ST_EMPTY) || (out_occupancy == '0)) &&
      ((out_status != spq_pkg::ST_FULL) || (out_occupancy == FULL_OCC)))
    else $error("occupancy disagrees with empty or full status");

  // back-to-back pops leave in non-increasing priority
  a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == spq_pkg::ST_POPPED &&
     $past(out_valid) && $past(out_status) == spq_pkg::ST_POPPED)
    |-> (out_priority <= $past(out_priority)))
    else $error("consecutive pops out of priority order");

  // insert items report inserted or full, pop items report popped or empty
  a_kind_status: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> ((out_status == spq_pkg::ST_INSERTED || out_status == spq_pkg::ST_FULL) ==
             ($past(in_kind) == spq_pkg::KIND_INSERT)))
    else $error("result status does not match item kind");

endmodule

bind stable_priority_queue_unit spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
`default_nettype wire
